@@ hw/rtl/sdda_pkg.sv @@
package sdda_pkg;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // Output buffer depth; it also bounds the beats in flight through the pipeline.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_DASH_MASK = 3'd0;
  localparam int DASH_BITS = 4;
  localparam logic [DASH_BITS-1:0] DASH_MASK_RESET = 4'hf;

endpackage

@@ hw/rtl/sdda_core.sv @@
module sdda_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  sdda_pkg::kind_t                       in_kind,
  input  logic signed [COORD_BITS-1:0]          in_start_x,
  input  logic signed [COORD_BITS-1:0]          in_start_y,
  input  logic signed [COORD_BITS-1:0]          in_end_x,
  input  logic signed [COORD_BITS-1:0]          in_end_y,
  input  logic [sdda_pkg::DASH_BITS-1:0]        dash_mask,
  output logic                                  res_valid,
  output logic signed [COORD_BITS:0]            res_point_x,
  output logic signed [COORD_BITS:0]            res_point_y,
  output logic                                  res_visible,
  output logic                                  res_last
);
  import sdda_pkg::*;

  localparam int D_W    = COORD_BITS + 1;
  localparam int N_W    = $clog2(COORD_BITS + 1);
  localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
  localparam int STEP_W = COORD_BITS + 1;
  localparam int OUT_W  = COORD_BITS + 1;
  localparam int RND_W  = ACC_W - FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // Stage 0: registered input beat.
  logic                         v0_r;
  kind_t                        kind0_r;
  logic signed [COORD_BITS-1:0] sx0_r, sy0_r, ex0_r, ey0_r;

  // Stage 1: deltas and exponent.
  logic                         v1_r;
  kind_t                        kind1_r;
  logic signed [COORD_BITS-1:0] sx1_r, sy1_r;
  logic signed [D_W-1:0]        dx1_r, dy1_r;
  logic [N_W-1:0]               n1_r;

  logic signed [D_W-1:0]        dx_nxt, dy_nxt;
  logic [COORD_BITS-1:0]        ax, ay, amax;
  logic [N_W-1:0]               n_nxt;

  // Line state.
  logic signed [ACC_W-1:0]      acc_x_r, acc_y_r, inc_x_r, inc_y_r;
  logic signed [ACC_W-1:0]      acc_x_nxt, acc_y_nxt, inc_x_nxt, inc_y_nxt;
  logic [STEP_W-1:0]            steps_r, steps_nxt;
  logic [1:0]                   pos_r, pos_nxt;

  // Stage 2: point before rounding.
  logic                         v2_r;
  logic signed [ACC_W-1:0]      px2_r, py2_r;
  logic                         vis2_r, last2_r;
  logic                         vis_nxt, last_nxt;

  function automatic logic [OUT_W-1:0] round_away(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    logic [RND_W-1:0] r;
    mag = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    sum = mag + HALF;
    r   = sum[ACC_W-1:FRAC_BITS];
    if (v[ACC_W-1]) begin
      r = ~r + RND_W'(1);
    end
    return r[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
    if (in_valid) begin
      kind0_r <= in_kind;
      sx0_r   <= in_start_x;
      sy0_r   <= in_start_y;
      ex0_r   <= in_end_x;
      ey0_r   <= in_end_y;
    end
  end

  always_comb begin
    dx_nxt = D_W'(ex0_r) - D_W'(sx0_r);
    dy_nxt = D_W'(ey0_r) - D_W'(sy0_r);
    ax     = dx_nxt[D_W-1] ? COORD_BITS'(-dx_nxt) : dx_nxt[COORD_BITS-1:0];
    ay     = dy_nxt[D_W-1] ? COORD_BITS'(-dy_nxt) : dy_nxt[COORD_BITS-1:0];
    amax   = (ax > ay) ? ax : ay;
    // Bit length of the larger magnitude; zero length gives n of zero.
    n_nxt  = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      if (amax[i]) begin
        n_nxt = N_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    if (v0_r) begin
      kind1_r <= kind0_r;
      sx1_r   <= sx0_r;
      sy1_r   <= sy0_r;
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      n1_r    <= n_nxt;
    end
  end

  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    inc_x_nxt = inc_x_r;
    inc_y_nxt = inc_y_r;
    steps_nxt = steps_r;
    pos_nxt   = pos_r;
    vis_nxt   = 1'b0;
    last_nxt  = 1'b1;
    if (v1_r) begin
      if (kind1_r == KIND_START) begin
        acc_x_nxt = (ACC_W'(sx1_r) <<< FRAC_BITS) + $signed(HALF);
        acc_y_nxt = (ACC_W'(sy1_r) <<< FRAC_BITS) + $signed(HALF);
        inc_x_nxt = (ACC_W'(dx1_r) <<< FRAC_BITS) >>> n1_r;
        inc_y_nxt = (ACC_W'(dy1_r) <<< FRAC_BITS) >>> n1_r;
        steps_nxt = STEP_W'(1) << n1_r;
        vis_nxt   = 1'b1;
        last_nxt  = 1'b0;
      end else if (steps_r != '0) begin
        acc_x_nxt = acc_x_r + inc_x_r;
        acc_y_nxt = acc_y_r + inc_y_r;
        steps_nxt = steps_r - STEP_W'(1);
        pos_nxt   = pos_r + 2'd1;
        vis_nxt   = dash_mask[pos_r];
        last_nxt  = (steps_r == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      inc_x_r <= '0;
      inc_y_r <= '0;
      steps_r <= '0;
      pos_r   <= '0;
      v2_r    <= 1'b0;
    end else begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      inc_x_r <= inc_x_nxt;
      inc_y_r <= inc_y_nxt;
      steps_r <= steps_nxt;
      pos_r   <= pos_nxt;
      v2_r    <= v1_r;
    end
    if (v1_r) begin
      px2_r   <= acc_x_nxt;
      py2_r   <= acc_y_nxt;
      vis2_r  <= vis_nxt;
      last2_r <= last_nxt;
    end
  end

  assign res_valid   = v2_r;
  assign res_point_x = round_away(px2_r);
  assign res_point_y = round_away(py2_r);
  assign res_visible = vis2_r;
  assign res_last    = last2_r;

endmodule

@@ hw/rtl/sdda_fifo.sv @@
module sdda_fifo #(
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);
  import sdda_pkg::*;

  logic [DATA_W-1:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               pop;

  // The upstream credit count keeps writes from reaching a full buffer.
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (wr_valid && !pop) begin
        count_r <= count_r + (FIFO_AW + 1)'(1);
      end else if (!wr_valid && pop) begin
        count_r <= count_r - (FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

@@ hw/rtl/symmetric_dda_line_stepper.sv @@
// Symmetric DDA line stepper. A beat with tuser 0 starts a line between the two endpoints in
// tdata and returns the start point plus one half; each beat with tuser 1 advances the line one
// step and returns the next point, all rounded half away from zero. A line of length L (the
// larger of |dx| and |dy|) takes 2^n steps, n being the bit length of L; tlast marks the final
// step, and a step beat with no line running repeats the last point with tuser (visible) low
// and tlast high. Step points are drawn according to the 4-bit dash mask at address 0, whose
// pattern position carries over from line to line. Every input beat yields exactly one output
// beat, through stages 0 to 2 and the output buffer. One beat is accepted per clock unless
// eight are outstanding; the rate is set by the single add of the line accumulators per cycle,
// and the eight-entry output buffer lets input continue while results wait.
module symmetric_dda_line_stepper #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero filled to whole bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  // kind
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // point_x, point_y from bit 0 up, zero filled to whole bytes
  output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] out_tdata,
  // visible
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [sdda_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import sdda_pkg::*;

  localparam int OUT_W  = COORD_BITS + 1;
  localparam int RES_W  = 2 * OUT_W + 2;
  localparam int ODATA_W = ((2*(COORD_BITS+1)+7)/8)*8;

  logic [DASH_BITS-1:0] dash_mask_r;
  logic [FIFO_AW:0]     credit_r;
  logic                 in_fire, out_fire;
  logic                 res_valid;
  logic signed [OUT_W-1:0] res_x, res_y;
  logic                 res_vis, res_last;
  logic [RES_W-1:0]     fifo_out;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_DASH_MASK) ? 32'(dash_mask_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_mask_r <= DASH_MASK_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && !cfg_paddr[2]) begin
      dash_mask_r <= cfg_pwdata[DASH_BITS-1:0];
    end
  end

  // Beats taken but not yet delivered; bounded by the output buffer depth.
  assign in_tready = (credit_r < (FIFO_AW + 1)'(FIFO_DEPTH));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else if (in_fire && !out_fire) begin
      credit_r <= credit_r + (FIFO_AW + 1)'(1);
    end else if (!in_fire && out_fire) begin
      credit_r <= credit_r - (FIFO_AW + 1)'(1);
    end
  end

  sdda_core #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_fire),
    .in_kind     (kind_t'(in_tuser)),
    .in_start_x  (in_tdata[COORD_BITS-1:0]),
    .in_start_y  (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_end_x    (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_end_y    (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .dash_mask   (dash_mask_r),
    .res_valid   (res_valid),
    .res_point_x (res_x),
    .res_point_y (res_y),
    .res_visible (res_vis),
    .res_last    (res_last)
  );

  sdda_fifo #(
    .DATA_W (RES_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_data  ({res_last, res_vis, res_y, res_x}),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (fifo_out)
  );

  assign out_tdata = ODATA_W'(fifo_out[2*OUT_W-1:0]);
  assign out_tuser = fifo_out[2*OUT_W];
  assign out_tlast = fifo_out[2*OUT_W+1];

endmodule
